// ----- hw/rtl/mcm_pkg.sv -----
// Shared widths, constants and types for the magnetometer consistency monitor.
`timescale 1ns / 1ps
`default_nettype none
package mcm_pkg;

  localparam int CW     = 28;   // vector component width used for lengths
  localparam int RW     = 56;   // square-root radicand width
  localparam int RT_W   = 28;   // square-root result width
  localparam int SUM_W  = 58;   // sum of squares width
  localparam int MB_W   = 29;   // multiplier B operand width
  localparam int NUM_W  = 60;   // divider numerator width
  localparam int DEN_W  = 28;   // divider denominator width
  localparam int Q_W    = 31;   // divider quotient width
  localparam int K_W    = 5;    // divider quotient bit count width
  localparam int E_W    = 17;   // relative error, Q0.16 up to 1.0
  localparam int UQ_W   = 32;   // unit vector component, Q1.30 signed
  localparam int DD_W   = UQ_W + 1;
  localparam int DP_W   = UQ_W + 9;
  localparam int REF_W  = 20;
  localparam int TH_W   = 16;
  localparam int CNT_W  = 3;
  localparam int DIFF_W = 10;
  localparam int TEN_W  = 10;
  localparam int LVL_W  = 2;
  localparam int TP_W   = E_W + 10;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 20;

  localparam logic [CFG_IDX_W-1:0] REG_REF_X     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_REF_Y     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_REF_Z     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_WARN_DEV  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ERROR_DEV = 3'd4;

  localparam logic [TH_W-1:0] WARN_DEV_RST  = 16'd3277;
  localparam logic [TH_W-1:0] ERROR_DEV_RST = 16'd9830;

  localparam logic signed [MB_W-1:0] COEF_OLD = 29'sd45875;
  localparam logic signed [MB_W-1:0] COEF_NEW = 29'sd19661;

  localparam logic [E_W-1:0] E_ONE = 17'h10000;
  localparam logic [K_W-1:0] K_ERR  = 5'd16;
  localparam logic [K_W-1:0] K_UNIT = 5'd31;

  localparam logic [DIFF_W-1:0] DIFF_LIM = 10'd500;
  localparam logic [TEN_W-1:0]  TEN_MAX  = 10'd1000;

  localparam logic [LVL_W-1:0] LVL_ABSENT = 2'd0;
  localparam logic [LVL_W-1:0] LVL_OK     = 2'd1;
  localparam logic [LVL_W-1:0] LVL_WARN   = 2'd2;
  localparam logic [LVL_W-1:0] LVL_ERR    = 2'd3;

  typedef struct packed {
    logic [LVL_W-1:0] level;
    logic [CNT_W-1:0] wc;
    logic [CNT_W-1:0] ec;
  } qual_t;

endpackage
`default_nettype wire

// ----- hw/rtl/mcm_mul.sv -----
// Shared signed multiplier with registered product.
`timescale 1ns / 1ps
`default_nettype none
module mcm_mul #(
  parameter int A_W = 29
) (
  input  wire logic                                clk,
  input  wire logic signed [A_W-1:0]               a,
  input  wire logic signed [mcm_pkg::MB_W-1:0]     b,
  output logic signed [A_W+mcm_pkg::MB_W-1:0]      p
);

  logic signed [A_W+mcm_pkg::MB_W-1:0] p_r;

  always_ff @(posedge clk) begin
    p_r <= (A_W+mcm_pkg::MB_W)'(a) * (A_W+mcm_pkg::MB_W)'(b);
  end

  assign p = p_r;

endmodule
`default_nettype wire

// ----- hw/rtl/mcm_sqrt.sv -----
// Iterative integer square root, one result bit per cycle.
`timescale 1ns / 1ps
`default_nettype none
module mcm_sqrt (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       start,
  input  wire logic [mcm_pkg::RW-1:0]     rad,
  output logic [mcm_pkg::RT_W-1:0]        root,
  output logic                            done
);

  logic [mcm_pkg::RW-1:0] x_r, r_r, bit_r, trial;
  logic busy_r, done_r;

  assign trial = r_r + bit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && bit_r[0]) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      x_r   <= rad;
      r_r   <= '0;
      bit_r <= mcm_pkg::RW'(1) << (mcm_pkg::RW - 2);
    end else if (busy_r) begin
      if (x_r >= trial) begin
        x_r <= x_r - trial;
        r_r <= (r_r >> 1) + bit_r;
      end else begin
        r_r <= r_r >> 1;
      end
      bit_r <= bit_r >> 2;
    end
  end

  assign root = r_r[mcm_pkg::RT_W-1:0];
  assign done = done_r;

endmodule
`default_nettype wire

// ----- hw/rtl/mcm_div.sv -----
// Iterative restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
`default_nettype none
module mcm_div (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        start,
  input  wire logic [mcm_pkg::NUM_W-1:0]   num,
  input  wire logic [mcm_pkg::DEN_W-1:0]   den,
  input  wire logic [mcm_pkg::K_W-1:0]     k,
  output logic [mcm_pkg::Q_W-1:0]          quot,
  output logic                             done
);

  logic [mcm_pkg::DEN_W-1:0] rem_r, den_r;
  logic [mcm_pkg::Q_W-1:0]   qsh_r;
  logic [mcm_pkg::K_W-1:0]   cnt_r;
  logic [mcm_pkg::DEN_W:0]   r2, rdiff;
  logic                      ge, busy_r, done_r;

  assign r2    = {rem_r, qsh_r[mcm_pkg::Q_W-1]};
  assign ge    = r2 >= {1'b0, den_r};
  assign rdiff = r2 - {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && cnt_r == mcm_pkg::K_W'(1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= mcm_pkg::DEN_W'(num >> k);
      qsh_r <= num[mcm_pkg::Q_W-1:0] << (mcm_pkg::K_W'(mcm_pkg::Q_W) - k);
      den_r <= den;
      cnt_r <= k;
    end else if (busy_r) begin
      rem_r <= ge ? rdiff[mcm_pkg::DEN_W-1:0] : r2[mcm_pkg::DEN_W-1:0];
      qsh_r <= {qsh_r[mcm_pkg::Q_W-2:0], ge};
      cnt_r <= cnt_r - mcm_pkg::K_W'(1);
    end
  end

  assign quot = qsh_r;
  assign done = done_r;

endmodule
`default_nettype wire

// ----- hw/rtl/magnetometer_consistency_monitor_unit.sv -----
// Magnetometer consistency monitor top level: sequencer, state and output word.
//
// One input word carries an onboard and an auxiliary 3-axis sample plus an
// aux-present flag; one output word returns per-axis unit vector differences,
// both magnitude errors and both alarm levels. Both channels use valid/stall.
// The config channel (cfg_valid/cfg_ready, ready whenever out of reset) writes
// the reference field and the two thresholds; write it only while the block is idle.
// From acceptance to output valid, the sequencer runs the shared square-root
// unit for each length and the shared divider for each unsaturated error and
// each unit vector component, back to back; unit vectors are formed only with
// aux. One word is in work at a time and in_stall is high meanwhile.
// The finished word sits in the output register; a new word is taken once
// it is loaded, even while the receiver holds out_stall. A result that is
// ready while the previous one is still stalled waits until it is taken.
// Synchronous reset clears the filters, hold counters and config registers
// (thresholds to 3277 and 9830) and drops out_valid.
`timescale 1ns / 1ps
`default_nettype none
module magnetometer_consistency_monitor_unit #(
  parameter int ALARM_HOLD  = 5,
  parameter int SAMPLE_BITS = 20
) (
  input  wire logic                                    clk,
  input  wire logic                                    rst_n,
  input  wire logic                                    in_valid,
  output logic                                         in_stall,
  input  wire logic signed [SAMPLE_BITS-1:0]           in_main_x,
  input  wire logic signed [SAMPLE_BITS-1:0]           in_main_y,
  input  wire logic signed [SAMPLE_BITS-1:0]           in_main_z,
  input  wire logic signed [SAMPLE_BITS-1:0]           in_aux_x,
  input  wire logic signed [SAMPLE_BITS-1:0]           in_aux_y,
  input  wire logic signed [SAMPLE_BITS-1:0]           in_aux_z,
  input  wire logic                                    in_aux_present,
  output logic                                         out_valid,
  input  wire logic                                    out_stall,
  output logic signed [mcm_pkg::DIFF_W-1:0]            out_diff_x,
  output logic signed [mcm_pkg::DIFF_W-1:0]            out_diff_y,
  output logic signed [mcm_pkg::DIFF_W-1:0]            out_diff_z,
  output logic [mcm_pkg::TEN_W-1:0]                    out_main_error_tenths,
  output logic [mcm_pkg::TEN_W-1:0]                    out_aux_error_tenths,
  output logic [mcm_pkg::LVL_W-1:0]                    out_main_level,
  output logic [mcm_pkg::LVL_W-1:0]                    out_aux_level,
  input  wire logic                                    cfg_valid,
  output logic                                         cfg_ready,
  input  wire logic [mcm_pkg::CFG_IDX_W-1:0]           cfg_index,
  input  wire logic [mcm_pkg::CFG_DATA_W-1:0]          cfg_data
);

  localparam int SW    = SAMPLE_BITS + 8;
  localparam int PRE   = (SAMPLE_BITS > 20) ? (SAMPLE_BITS - 20) : 0;
  localparam int AW    = (SW > mcm_pkg::CW) ? SW : mcm_pkg::CW;
  localparam int PW    = AW + mcm_pkg::MB_W;
  localparam int ACC_W = SW + 18;
  localparam int MAG_W = mcm_pkg::RT_W + PRE;

  typedef enum logic [9:0] {
    ST_IDLE      = 10'b00_0000_0001,
    ST_SMOOTH    = 10'b00_0000_0010,
    ST_LOAD      = 10'b00_0000_0100,
    ST_SQ        = 10'b00_0000_1000,
    ST_SQRT_GO   = 10'b00_0001_0000,
    ST_SQRT_WAIT = 10'b00_0010_0000,
    ST_UDIV_SET  = 10'b00_0100_0000,
    ST_DIV_GO    = 10'b00_1000_0000,
    ST_DIV_WAIT  = 10'b01_0000_0000,
    ST_FIN       = 10'b10_0000_0000
  } state_t;

  typedef enum logic [4:0] {
    J_REF   = 5'b00001,
    J_MRAW  = 5'b00010,
    J_ARAW  = 5'b00100,
    J_MUNIT = 5'b01000,
    J_AUNIT = 5'b10000
  } job_t;

  state_t state_r;
  job_t   job_r, job_next;
  logic   job_last, is_unit;

  logic [1:0] ax_r, sub_r;
  logic       sm_aux_r, pres_r, zero_r;

  logic signed [SAMPLE_BITS-1:0] m_r [3];
  logic signed [SAMPLE_BITS-1:0] a_r [3];
  logic signed [SW-1:0]          main_st_r [3];
  logic signed [SW-1:0]          aux_st_r [3];
  logic signed [ACC_W-1:0]       acc_r, acc_sum;
  logic signed [SW-1:0]          st_cur, st_new;
  logic signed [SAMPLE_BITS-1:0] x_cur;

  logic signed [mcm_pkg::CW-1:0] vec_r [3];
  logic signed [mcm_pkg::CW-1:0] src [3];
  logic [mcm_pkg::SUM_W-1:0]     sum_r;
  logic [mcm_pkg::RT_W-1:0]      mref_r;
  logic [mcm_pkg::NUM_W-1:0]     num_r, unit_num;
  logic [mcm_pkg::DEN_W-1:0]     den_r;
  logic [mcm_pkg::K_W-1:0]       k_r;
  logic [mcm_pkg::E_W-1:0]       em_r, ea_r;
  logic signed [mcm_pkg::UQ_W-1:0] nm_r [3];
  logic signed [mcm_pkg::UQ_W-1:0] na_r [3];
  logic signed [mcm_pkg::UQ_W-1:0] uq_val;
  logic [mcm_pkg::CW-1:0]        absc;

  logic [mcm_pkg::CNT_W-1:0] mwc_r, mec_r, awc_r, aec_r;
  logic signed [mcm_pkg::REF_W-1:0] ref_r [3];
  logic [mcm_pkg::TH_W-1:0]  warn_r, errth_r;

  logic [MAG_W-1:0]          mag, mref_w, dabs;
  logic                      sat;

  logic signed [AW-1:0]            mul_a;
  logic signed [mcm_pkg::MB_W-1:0] mul_b;
  logic signed [PW-1:0]            mul_p;

  logic                        sq_start, sq_done;
  logic [mcm_pkg::RW-1:0]      sq_rad;
  logic [mcm_pkg::RT_W-1:0]    sq_root;
  logic                        div_start, div_done;
  logic [mcm_pkg::Q_W-1:0]     div_q;

  mcm_pkg::qual_t qm, qa;
  logic out_valid_r, fin_load;

  function automatic mcm_pkg::qual_t qualify(input logic [mcm_pkg::E_W-1:0] e,
                                             input logic [mcm_pkg::CNT_W-1:0] wc,
                                             input logic [mcm_pkg::CNT_W-1:0] ec,
                                             input logic [mcm_pkg::TH_W-1:0] wth,
                                             input logic [mcm_pkg::TH_W-1:0] eth);
    mcm_pkg::qual_t q;
    q.level = mcm_pkg::LVL_OK;
    q.wc    = wc;
    q.ec    = ec;
    if (e < mcm_pkg::E_W'(wth)) begin
      q.wc = '0;
      q.ec = '0;
    end
    if (e < mcm_pkg::E_W'(eth)) begin
      q.ec = '0;
      if (q.wc > mcm_pkg::CNT_W'(ALARM_HOLD)) q.level = mcm_pkg::LVL_WARN;
      else q.wc = q.wc + mcm_pkg::CNT_W'(1);
    end
    if (q.ec > mcm_pkg::CNT_W'(ALARM_HOLD)) q.level = mcm_pkg::LVL_ERR;
    else q.ec = q.ec + mcm_pkg::CNT_W'(1);
    return q;
  endfunction

  function automatic logic [mcm_pkg::TEN_W-1:0] tenths(input logic [mcm_pkg::E_W-1:0] e);
    logic [mcm_pkg::TP_W-1:0] t;
    t = (mcm_pkg::TP_W'(e) * mcm_pkg::TP_W'(1000) + mcm_pkg::TP_W'(32768)) >> 16;
    return (t > mcm_pkg::TP_W'(mcm_pkg::TEN_MAX)) ? mcm_pkg::TEN_MAX
                                                   : t[mcm_pkg::TEN_W-1:0];
  endfunction

  function automatic logic signed [mcm_pkg::DIFF_W-1:0] diff_calc(
      input logic signed [mcm_pkg::UQ_W-1:0] a, input logic signed [mcm_pkg::UQ_W-1:0] b);
    logic signed [mcm_pkg::DD_W-1:0] dd;
    logic signed [mcm_pkg::DP_W-1:0] pr;
    logic [mcm_pkg::DP_W-1:0]        pm, q;
    logic [mcm_pkg::DIFF_W-1:0]      lim;
    dd  = mcm_pkg::DD_W'(a) - mcm_pkg::DD_W'(b);
    pr  = mcm_pkg::DP_W'(dd) * mcm_pkg::DP_W'(250);
    pm  = (pr < 0) ? mcm_pkg::DP_W'(-pr) : mcm_pkg::DP_W'(pr);
    q   = (pm + (mcm_pkg::DP_W'(1) << 29)) >> 30;
    lim = (q > mcm_pkg::DP_W'(mcm_pkg::DIFF_LIM)) ? mcm_pkg::DIFF_LIM
                                                  : q[mcm_pkg::DIFF_W-1:0];
    return (pr < 0) ? -signed'(lim) : signed'(lim);
  endfunction

  mcm_mul #(.A_W(AW)) u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (mul_p)
  );

  mcm_sqrt u_sqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .start (sq_start),
    .rad   (sq_rad),
    .root  (sq_root),
    .done  (sq_done)
  );

  mcm_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (num_r),
    .den   (den_r),
    .k     (k_r),
    .quot  (div_q),
    .done  (div_done)
  );

  assign in_stall  = (state_r != ST_IDLE) || !rst_n;
  assign cfg_ready = rst_n;
  assign out_valid = out_valid_r;
  assign sq_start  = (state_r == ST_SQRT_GO);
  assign div_start = (state_r == ST_DIV_GO);
  assign is_unit   = (job_r == J_MUNIT) || (job_r == J_AUNIT);
  assign sq_rad    = is_unit ? mcm_pkg::RW'(sum_r) : mcm_pkg::RW'(sum_r << 16);
  assign job_last  = (job_r == J_AUNIT) || ((job_r == J_MRAW) && !pres_r);
  assign fin_load  = (state_r == ST_FIN) && (!out_valid_r || !out_stall);

  always_comb begin
    unique case (job_r)
      J_REF:   job_next = J_MRAW;
      J_MRAW:  job_next = J_ARAW;
      J_ARAW:  job_next = J_MUNIT;
      J_MUNIT: job_next = J_AUNIT;
      default: job_next = J_REF;
    endcase
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      case (job_r)
        J_REF:   src[i] = mcm_pkg::CW'(ref_r[i]);
        J_MRAW:  src[i] = mcm_pkg::CW'(m_r[i] >>> PRE);
        J_ARAW:  src[i] = mcm_pkg::CW'(a_r[i] >>> PRE);
        J_MUNIT: src[i] = mcm_pkg::CW'(main_st_r[i] >>> PRE);
        default: src[i] = mcm_pkg::CW'(aux_st_r[i] >>> PRE);
      endcase
    end
  end

  always_comb begin
    st_cur  = sm_aux_r ? aux_st_r[ax_r] : main_st_r[ax_r];
    x_cur   = sm_aux_r ? a_r[ax_r] : m_r[ax_r];
    acc_sum = acc_r + (ACC_W'(mul_p) <<< 8) + ACC_W'(32768);
    st_new  = SW'(acc_sum >>> 16);
    if (state_r == ST_SMOOTH && sub_r == 2'd0) begin
      mul_a = AW'(st_cur);
      mul_b = mcm_pkg::COEF_OLD;
    end else if (state_r == ST_SMOOTH) begin
      mul_a = AW'(x_cur);
      mul_b = mcm_pkg::COEF_NEW;
    end else begin
      mul_a = AW'(vec_r[ax_r]);
      mul_b = mcm_pkg::MB_W'(vec_r[ax_r]);
    end
  end

  always_comb begin
    mag    = MAG_W'(sq_root) << PRE;
    mref_w = MAG_W'(mref_r);
    dabs   = (mag >= mref_w) ? (mag - mref_w) : (mref_w - mag);
    sat    = (mref_r == '0) || (dabs >= mref_w);
    absc   = (vec_r[ax_r] < 0) ? mcm_pkg::CW'(-vec_r[ax_r]) : mcm_pkg::CW'(vec_r[ax_r]);
    unit_num = (mcm_pkg::NUM_W'(absc) << 30) + mcm_pkg::NUM_W'(den_r >> 1);
    uq_val = (vec_r[ax_r] < 0) ? -signed'(mcm_pkg::UQ_W'(div_q))
                               : signed'(mcm_pkg::UQ_W'(div_q));
    qm = qualify(em_r, mwc_r, mec_r, warn_r, errth_r);
    qa = qualify(ea_r, awc_r, aec_r, warn_r, errth_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      job_r       <= J_REF;
      out_valid_r <= 1'b0;
      mwc_r       <= '0;
      mec_r       <= '0;
      awc_r       <= '0;
      aec_r       <= '0;
      warn_r      <= mcm_pkg::WARN_DEV_RST;
      errth_r     <= mcm_pkg::ERROR_DEV_RST;
      for (int i = 0; i < 3; i++) begin
        ref_r[i]     <= '0;
        main_st_r[i] <= '0;
        aux_st_r[i]  <= '0;
      end
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index)
          mcm_pkg::REG_REF_X:     ref_r[0] <= signed'(cfg_data);
          mcm_pkg::REG_REF_Y:     ref_r[1] <= signed'(cfg_data);
          mcm_pkg::REG_REF_Z:     ref_r[2] <= signed'(cfg_data);
          mcm_pkg::REG_WARN_DEV:  warn_r   <= cfg_data[mcm_pkg::TH_W-1:0];
          mcm_pkg::REG_ERROR_DEV: errth_r  <= cfg_data[mcm_pkg::TH_W-1:0];
          default: ;
        endcase
      end

      if (fin_load) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;

      unique case (state_r)
        ST_IDLE: begin
          if (in_valid) begin
            m_r[0]   <= in_main_x;
            m_r[1]   <= in_main_y;
            m_r[2]   <= in_main_z;
            a_r[0]   <= in_aux_x;
            a_r[1]   <= in_aux_y;
            a_r[2]   <= in_aux_z;
            pres_r   <= in_aux_present;
            zero_r   <= 1'b0;
            ax_r     <= 2'd0;
            sub_r    <= 2'd0;
            sm_aux_r <= 1'b0;
            if (!in_aux_present) begin
              for (int i = 0; i < 3; i++) aux_st_r[i] <= '0;
            end
            state_r <= ST_SMOOTH;
          end
        end
        ST_SMOOTH: begin
          if (sub_r == 2'd0) begin
            sub_r <= 2'd1;
          end else if (sub_r == 2'd1) begin
            acc_r <= ACC_W'(mul_p);
            sub_r <= 2'd2;
          end else begin
            if (sm_aux_r) aux_st_r[ax_r] <= st_new;
            else main_st_r[ax_r] <= st_new;
            sub_r <= 2'd0;
            if (ax_r == 2'd2) begin
              ax_r <= 2'd0;
              if (!sm_aux_r && pres_r) begin
                sm_aux_r <= 1'b1;
              end else begin
                job_r   <= J_REF;
                state_r <= ST_LOAD;
              end
            end else begin
              ax_r <= ax_r + 2'd1;
            end
          end
        end
        ST_LOAD: begin
          for (int i = 0; i < 3; i++) vec_r[i] <= src[i];
          sum_r   <= '0;
          ax_r    <= 2'd0;
          sub_r   <= 2'd0;
          state_r <= ST_SQ;
        end
        ST_SQ: begin
          if (sub_r == 2'd0) begin
            sub_r <= 2'd1;
          end else begin
            sum_r <= sum_r + mcm_pkg::SUM_W'(mul_p[2*mcm_pkg::CW-1:0]);
            sub_r <= 2'd0;
            if (ax_r == 2'd2) state_r <= ST_SQRT_GO;
            else ax_r <= ax_r + 2'd1;
          end
        end
        ST_SQRT_GO: begin
          state_r <= ST_SQRT_WAIT;
        end
        ST_SQRT_WAIT: begin
          if (sq_done) begin
            if (job_r == J_REF) begin
              mref_r  <= sq_root;
              job_r   <= job_next;
              state_r <= ST_LOAD;
            end else if (is_unit) begin
              if (sq_root == '0) begin
                zero_r  <= 1'b1;
                state_r <= ST_FIN;
              end else begin
                den_r   <= sq_root;
                ax_r    <= 2'd0;
                state_r <= ST_UDIV_SET;
              end
            end else if (sat) begin
              if (job_r == J_MRAW) em_r <= mcm_pkg::E_ONE;
              else ea_r <= mcm_pkg::E_ONE;
              if (!job_last) job_r <= job_next;
              state_r <= job_last ? ST_FIN : ST_LOAD;
            end else begin
              num_r   <= mcm_pkg::NUM_W'(dabs) << 16;
              den_r   <= mref_r;
              k_r     <= mcm_pkg::K_ERR;
              state_r <= ST_DIV_GO;
            end
          end
        end
        ST_UDIV_SET: begin
          num_r   <= unit_num;
          k_r     <= mcm_pkg::K_UNIT;
          state_r <= ST_DIV_GO;
        end
        ST_DIV_GO: begin
          state_r <= ST_DIV_WAIT;
        end
        ST_DIV_WAIT: begin
          if (div_done) begin
            if (is_unit) begin
              if (job_r == J_MUNIT) nm_r[ax_r] <= uq_val;
              else na_r[ax_r] <= uq_val;
              if (ax_r == 2'd2) begin
                if (!job_last) job_r <= job_next;
                state_r <= job_last ? ST_FIN : ST_LOAD;
              end else begin
                ax_r    <= ax_r + 2'd1;
                state_r <= ST_UDIV_SET;
              end
            end else begin
              if (job_r == J_MRAW) em_r <= div_q[mcm_pkg::E_W-1:0];
              else ea_r <= div_q[mcm_pkg::E_W-1:0];
              if (!job_last) job_r <= job_next;
              state_r <= job_last ? ST_FIN : ST_LOAD;
            end
          end
        end
        ST_FIN: begin
          if (fin_load) begin
            mwc_r <= qm.wc;
            mec_r <= qm.ec;
            if (pres_r) begin
              awc_r <= qa.wc;
              aec_r <= qa.ec;
            end
            state_r <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (fin_load) begin
      if (pres_r && !zero_r) begin
        out_diff_x <= diff_calc(nm_r[0], na_r[0]);
        out_diff_y <= diff_calc(nm_r[1], na_r[1]);
        out_diff_z <= diff_calc(nm_r[2], na_r[2]);
      end else begin
        out_diff_x <= '0;
        out_diff_y <= '0;
        out_diff_z <= '0;
      end
      out_main_error_tenths <= tenths(em_r);
      out_main_level        <= qm.level;
      out_aux_error_tenths  <= pres_r ? tenths(ea_r) : '0;
      out_aux_level         <= pres_r ? qa.level : mcm_pkg::LVL_ABSENT;
    end
  end

endmodule
`default_nettype wire

// ----- hw/rtl/mcm_chk.sv -----
// Port-level checker for the magnetometer consistency monitor, bound to the top.
`timescale 1ns / 1ps
`default_nettype none
module mcm_chk (
  input wire logic                               clk,
  input wire logic                               rst_n,
  input wire logic                               in_valid,
  input wire logic                               in_stall,
  input wire logic                               out_valid,
  input wire logic                               out_stall,
  input wire logic signed [mcm_pkg::DIFF_W-1:0]  out_diff_x,
  input wire logic signed [mcm_pkg::DIFF_W-1:0]  out_diff_y,
  input wire logic signed [mcm_pkg::DIFF_W-1:0]  out_diff_z,
  input wire logic [mcm_pkg::TEN_W-1:0]          out_main_error_tenths,
  input wire logic [mcm_pkg::TEN_W-1:0]          out_aux_error_tenths,
  input wire logic [mcm_pkg::LVL_W-1:0]          out_main_level,
  input wire logic [mcm_pkg::LVL_W-1:0]          out_aux_level
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_diff_x) && $stable(out_main_level))
    else $error("stalled output word changed");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken again right after an accept");

  a_main_present: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_main_level != mcm_pkg::LVL_ABSENT
                  && out_main_error_tenths <= mcm_pkg::TEN_MAX)
    else $error("bad main error or level");

  a_aux_absent: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_aux_level == mcm_pkg::LVL_ABSENT |->
      out_diff_x == '0 && out_diff_y == '0 && out_diff_z == '0
      && out_aux_error_tenths == '0)
    else $error("aux absent but diffs or aux error nonzero");

endmodule

bind magnetometer_consistency_monitor_unit mcm_chk u_mcm_chk (
  .clk                   (clk),
  .rst_n                 (rst_n),
  .in_valid              (in_valid),
  .in_stall              (in_stall),
  .out_valid             (out_valid),
  .out_stall             (out_stall),
  .out_diff_x            (out_diff_x),
  .out_diff_y            (out_diff_y),
  .out_diff_z            (out_diff_z),
  .out_main_error_tenths (out_main_error_tenths),
  .out_aux_error_tenths  (out_aux_error_tenths),
  .out_main_level        (out_main_level),
  .out_aux_level         (out_aux_level)
);
`default_nettype wire

// ----- tb/magnetometer_consistency_monitor_unit_tb.sv -----
// Self-checking testbench for the magnetometer consistency monitor unit.
`timescale 1ns / 1ps
module magnetometer_consistency_monitor_unit_tb;

  localparam int SB = 20;

  typedef struct {
    logic signed [SB-1:0] mx, my, mz, ax, ay, az;
    logic                 present;
  } sample_t;

  typedef struct {
    logic signed [mcm_pkg::DIFF_W-1:0] dif [3];
    logic [mcm_pkg::TEN_W-1:0]         main_ten, aux_ten;
    logic [mcm_pkg::LVL_W-1:0]         main_lvl, aux_lvl;
  } report_t;

  class consistency_board;
    longint          main_st [3];
    longint          aux_st [3];
    int              mwc, mec, awc, aec;
    longint          rx, ry, rz;
    longint unsigned warn_th, err_th;
    report_t         pending_q [$];
    int              mismatches, checked, unexpected;

    function new();
      warn_th = mcm_pkg::WARN_DEV_RST;
      err_th  = mcm_pkg::ERROR_DEV_RST;
    endfunction

    function void write_reg(logic [mcm_pkg::CFG_IDX_W-1:0] idx,
                            logic [mcm_pkg::CFG_DATA_W-1:0] val);
      case (idx)
        mcm_pkg::REG_REF_X:     rx = longint'($signed(val));
        mcm_pkg::REG_REF_Y:     ry = longint'($signed(val));
        mcm_pkg::REG_REF_Z:     rz = longint'($signed(val));
        mcm_pkg::REG_WARN_DEV:  warn_th = val[mcm_pkg::TH_W-1:0];
        mcm_pkg::REG_ERROR_DEV: err_th = val[mcm_pkg::TH_W-1:0];
        default: ;
      endcase
    endfunction

    function longint unsigned uabs(longint v);
      return v < 0 ? longint'(-v) : v;
    endfunction

    function longint unsigned isqrt(longint unsigned x);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > x) b = b >> 2;
      while (b != 0) begin
        if (x >= r + b) begin
          x = x - (r + b);
          r = (r >> 1) + b;
        end else begin
          r = r >> 1;
        end
        b = b >> 2;
      end
      return r;
    endfunction

    function longint filt(longint s, longint x);
      longint acc;
      acc = s * 45875 + x * 256 * 19661 + 32768;
      return acc >>> 16;
    endfunction

    function longint unsigned mag_q8(longint a, longint b, longint c);
      longint unsigned s;
      s = uabs(a) * uabs(a) + uabs(b) * uabs(b) + uabs(c) * uabs(c);
      return isqrt(s << 16);
    endfunction

    function bit unit_of(input longint s [3], output longint n [3]);
      longint unsigned sum, len, q;
      sum = 0;
      for (int i = 0; i < 3; i++) sum += uabs(s[i]) * uabs(s[i]);
      len = isqrt(sum);
      for (int i = 0; i < 3; i++) n[i] = 0;
      if (len == 0) return 0;
      for (int i = 0; i < 3; i++) begin
        q = ((uabs(s[i]) << 30) + len / 2) / len;
        n[i] = s[i] < 0 ? -longint'(q) : longint'(q);
      end
      return 1;
    endfunction

    function longint unsigned rel_err(longint a, longint b, longint c,
                                      longint unsigned mref);
      longint unsigned m, d, e;
      m = mag_q8(a, b, c);
      if (mref == 0) return 64'd65536;
      d = m > mref ? m - mref : mref - m;
      e = (d << 16) / mref;
      return e > 64'd65536 ? 64'd65536 : e;
    endfunction

    function logic [mcm_pkg::LVL_W-1:0] qualify(longint unsigned e, inout int wc,
                                                inout int ec);
      logic [mcm_pkg::LVL_W-1:0] lv;
      lv = mcm_pkg::LVL_OK;
      if (e < warn_th) begin
        wc = 0;
        ec = 0;
      end
      if (e < err_th) begin
        ec = 0;
        if (wc > 5) lv = mcm_pkg::LVL_WARN;
        else wc++;
      end
      if (ec > 5) lv = mcm_pkg::LVL_ERR;
      else ec++;
      return lv;
    endfunction

    function logic [mcm_pkg::TEN_W-1:0] tenths(longint unsigned e);
      longint unsigned t;
      t = (e * 1000 + 32768) >> 16;
      return t > 1000 ? mcm_pkg::TEN_MAX : t[mcm_pkg::TEN_W-1:0];
    endfunction

    function void note_input(sample_t s);
      longint m [3], a [3], nm [3], na [3];
      longint d, r;
      longint unsigned q, mref, em, ea;
      bit ok_m, ok_a;
      report_t rep;
      m[0] = s.mx; m[1] = s.my; m[2] = s.mz;
      a[0] = s.ax; a[1] = s.ay; a[2] = s.az;
      for (int i = 0; i < 3; i++) begin
        main_st[i] = filt(main_st[i], m[i]);
        rep.dif[i] = '0;
      end
      if (s.present) begin
        for (int i = 0; i < 3; i++) aux_st[i] = filt(aux_st[i], a[i]);
        ok_m = unit_of(main_st, nm);
        ok_a = unit_of(aux_st, na);
        if (ok_m && ok_a) begin
          for (int i = 0; i < 3; i++) begin
            d = (nm[i] - na[i]) * 250;
            q = (uabs(d) + (64'd1 << 29)) >> 30;
            r = d < 0 ? -longint'(q) : longint'(q);
            if (r > 500) r = 500;
            if (r < -500) r = -500;
            rep.dif[i] = r[mcm_pkg::DIFF_W-1:0];
          end
        end
      end else begin
        for (int i = 0; i < 3; i++) aux_st[i] = 0;
      end
      mref = mag_q8(rx, ry, rz);
      em = rel_err(m[0], m[1], m[2], mref);
      rep.main_ten = tenths(em);
      rep.main_lvl = qualify(em, mwc, mec);
      rep.aux_ten = '0;
      rep.aux_lvl = mcm_pkg::LVL_ABSENT;
      if (s.present) begin
        ea = rel_err(a[0], a[1], a[2], mref);
        rep.aux_ten = tenths(ea);
        rep.aux_lvl = qualify(ea, awc, aec);
      end
      pending_q.push_back(rep);
    endfunction

    function void check_result(report_t got);
      report_t w;
      if (pending_q.size() == 0) begin
        unexpected++;
        mismatches++;
        if (mismatches <= 10) $display("result word with nothing expected");
        return;
      end
      w = pending_q.pop_front();
      checked++;
      if (got.dif[0] !== w.dif[0] || got.dif[1] !== w.dif[1] || got.dif[2] !== w.dif[2] ||
          got.main_ten !== w.main_ten || got.aux_ten !== w.aux_ten ||
          got.main_lvl !== w.main_lvl || got.aux_lvl !== w.aux_lvl) begin
        mismatches++;
        if (mismatches <= 10)
          $display("word %0d: exp %0d %0d %0d %0d %0d %0d %0d, got %0d %0d %0d %0d %0d %0d %0d",
                   checked, w.dif[0], w.dif[1], w.dif[2], w.main_ten, w.aux_ten,
                   w.main_lvl, w.aux_lvl, got.dif[0], got.dif[1], got.dif[2],
                   got.main_ten, got.aux_ten, got.main_lvl, got.aux_lvl);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [SB-1:0] in_main_x = '0, in_main_y = '0, in_main_z = '0;
  logic signed [SB-1:0] in_aux_x = '0, in_aux_y = '0, in_aux_z = '0;
  logic in_aux_present = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [mcm_pkg::DIFF_W-1:0] out_diff_x, out_diff_y, out_diff_z;
  logic [mcm_pkg::TEN_W-1:0] out_main_error_tenths, out_aux_error_tenths;
  logic [mcm_pkg::LVL_W-1:0] out_main_level, out_aux_level;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [mcm_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [mcm_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  consistency_board board;
  bit idle_en = 1'b1;
  int hold_left = 0;
  int burst_left = 0;
  int words_sent = 0;
  int absent_sent = 0;
  longint cur_ref [3];

  magnetometer_consistency_monitor_unit dut (.*);

  always #2 clk = ~clk;

  always @(posedge clk) begin
    report_t got;
    if (rst_n) begin
      if (in_valid && !in_stall)
        board.note_input('{in_main_x, in_main_y, in_main_z, in_aux_x, in_aux_y, in_aux_z,
                           in_aux_present});
      if (out_valid && !out_stall) begin
        got.dif[0] = out_diff_x;
        got.dif[1] = out_diff_y;
        got.dif[2] = out_diff_z;
        got.main_ten = out_main_error_tenths;
        got.aux_ten = out_aux_error_tenths;
        got.main_lvl = out_main_level;
        got.aux_lvl = out_aux_level;
        board.check_result(got);
      end
    end
  end

  // receiver: random stall bursts plus a long hold on request
  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else if (burst_left > 0) begin
      out_stall <= 1'b1;
      burst_left--;
    end else if (idle_en && $urandom_range(0, 7) == 0) begin
      out_stall <= 1'b1;
      burst_left = $urandom_range(0, 5);
    end else begin
      out_stall <= 1'b0;
    end
  end

  task automatic send(sample_t s);
    in_valid <= 1'b1;
    in_main_x <= s.mx; in_main_y <= s.my; in_main_z <= s.mz;
    in_aux_x <= s.ax; in_aux_y <= s.ay; in_aux_z <= s.az;
    in_aux_present <= s.present;
    do @(posedge clk); while (in_stall);
    words_sent++;
    if (!s.present) absent_sent++;
    if (idle_en && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (board.pending_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(logic [mcm_pkg::CFG_IDX_W-1:0] idx,
                           logic [mcm_pkg::CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    board.write_reg(idx, val);
  endtask

  task automatic set_config(int x, int y, int z, int warn, int err);
    write_reg(mcm_pkg::REG_REF_X, x[mcm_pkg::CFG_DATA_W-1:0]);
    write_reg(mcm_pkg::REG_REF_Y, y[mcm_pkg::CFG_DATA_W-1:0]);
    write_reg(mcm_pkg::REG_REF_Z, z[mcm_pkg::CFG_DATA_W-1:0]);
    write_reg(mcm_pkg::REG_WARN_DEV, warn[mcm_pkg::CFG_DATA_W-1:0]);
    write_reg(mcm_pkg::REG_ERROR_DEV, err[mcm_pkg::CFG_DATA_W-1:0]);
    cfg_valid <= 1'b0;
    cur_ref[0] = longint'(x); cur_ref[1] = longint'(y); cur_ref[2] = longint'(z);
  endtask

  function automatic logic signed [SB-1:0] near(longint c, int spread);
    longint v;
    v = c + longint'($urandom_range(0, 2 * spread)) - longint'(spread);
    if (v > 524287) v = 524287;
    if (v < -524288) v = -524288;
    return v[SB-1:0];
  endfunction

  function automatic sample_t rand_word(int spread, bit present, bit wild);
    sample_t s;
    if (wild) begin
      s = '{SB'($urandom()), SB'($urandom()), SB'($urandom()), SB'($urandom()),
            SB'($urandom()), SB'($urandom()), present};
    end else begin
      s.mx = near(cur_ref[0], spread); s.my = near(cur_ref[1], spread);
      s.mz = near(cur_ref[2], spread);
      s.ax = near(cur_ref[0], spread); s.ay = near(cur_ref[1], spread);
      s.az = near(cur_ref[2], spread);
      s.present = present;
    end
    return s;
  endfunction

  // runs of words with one deviation level so the hold counters can fire
  task automatic random_phase(int count);
    int len, spread, mag, sel;
    bit broken;
    mag = 1;
    for (int i = 0; i < 3; i++)
      if (cur_ref[i] > mag || -cur_ref[i] > mag)
        mag = int'((cur_ref[i] < 0) ? -cur_ref[i] : cur_ref[i]);
    while (count > 0) begin
      len = $urandom_range(6, 14);
      sel = $urandom_range(0, 19);
      case ($urandom_range(0, 3))
        0: spread = 0;
        1: spread = mag / 40;
        2: spread = mag / 12;
        default: spread = mag / 3;
      endcase
      broken = (sel == 0);
      for (int k = 0; k < len && count > 0; k++) begin
        send(rand_word(spread,
                       broken ? ($urandom_range(0, 1) == 1) : ($urandom_range(0, 9) != 0),
                       sel == 1 || sel == 2));
        count--;
      end
    end
  endtask

  sample_t dir_q [$];

  initial begin
    board = new();
    cur_ref = '{0, 0, 0};
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset config: zero reference saturates the error
    dir_q = '{
      '{0, 0, 0, 0, 0, 0, 1'b1},
      '{524287, 524287, 524287, 524287, 524287, 524287, 1'b1},
      '{-524288, -524288, -524288, -524288, -524288, -524288, 1'b1},
      '{524287, -524288, 524287, -524288, 524287, -524288, 1'b1},
      '{349525, -349526, 349525, -349526, 349525, -349526, 1'b1},
      '{1000, 2000, 3000, 4000, 5000, 6000, 1'b0},
      '{0, 0, 0, -700, 800, 900, 1'b1},
      '{1, 0, 0, 0, 0, 0, 1'b1},
      '{-1, -1, -1, -1, -1, -1, 1'b1}};
    foreach (dir_q[i]) send(dir_q[i]);
    drain();

    set_config(30000, -20000, 15000, 3277, 9830);
    dir_q = '{
      '{30000, -20000, 15000, 30000, -20000, 15000, 1'b1},
      '{60000, -40000, 30000, -30000, 20000, -15000, 1'b1},
      '{30000, -20000, 15000, 33000, -22000, 16500, 1'b1},
      '{0, 0, 0, 30000, -20000, 15000, 1'b0}};
    for (int r = 0; r < 8; r++) foreach (dir_q[i]) send(dir_q[i]);
    random_phase(300);
    // long receiver hold while words keep coming
    hold_left = 3000;
    random_phase(10);
    drain();
    random_phase(200);
    drain();

    set_config(-524288, 524287, -524288, 0, 65535);
    random_phase(350);
    drain();

    set_config(1, 0, 0, 65535, 0);
    random_phase(250);
    drain();

    set_config(-20000, 5000, -40000, 655, 6553);
    random_phase(400);
    drain();

    idle_en = 1'b0;
    set_config(12345, 23456, -34567, 1310, 13107);
    random_phase(400);
    drain();

    $display("%0d sample words (%0d without aux), %0d results checked over six settings",
             words_sent, absent_sent, board.checked);
    if (board.mismatches == 0 && board.pending_q.size() == 0)
      $display("magnetometer_consistency_monitor_unit: match");
    else
      $display("magnetometer_consistency_monitor_unit: mismatch");
    $finish;
  end

  initial begin
    #40_000_000;
    $display("magnetometer_consistency_monitor_unit: mismatch");
    $finish;
  end

endmodule
